// ===== design/icsum_pkg.sv =====
`default_nettype none

package icsum_pkg;

  // Item kinds carried on the input tuser bus.
  typedef enum logic [1:0] {
    KIND_ADDR    = 2'd0,
    KIND_HDR     = 2'd1,
    KIND_PAYLOAD = 2'd2
  } kind_e;

  localparam int unsigned SumW   = 16;
  localparam int unsigned CountW = 17;
  localparam int unsigned TotalW = 19;

  localparam logic [SumW-1:0]   IcmpHeaderBytes = 16'd8;
  localparam logic [CountW-1:0] PayloadLimit    = 17'd65527;
  localparam logic [CountW-1:0] CountMax        = 17'h1ffff;

  // One input item after unpacking from the stream bus.
  typedef struct packed {
    kind_e        kind;
    logic [63:0]  address_chunk;
    logic [7:0]   next_header;
    logic [7:0]   icmp_type;
    logic [7:0]   icmp_code;
    logic [15:0]  ident;
    logic [15:0]  sequence_req;
    logic [7:0]   payload_byte;
    logic         last;
  } in_item_t;

  // Message state handed from the accumulator to the finishing stage.
  typedef struct packed {
    logic [SumW-1:0]   sum;
    logic [SumW-1:0]   pad_word;
    logic [CountW-1:0] count;
  } fin_t;

  // Fold a wide sum back into 16 bits with end-around carry. Two folds are
  // enough for a sum of up to eight 16-bit words.
  function automatic logic [SumW-1:0] ones_fold(input logic [TotalW-1:0] x);
    logic [SumW:0] t1;
    logic [SumW:0] t2;
    t1 = {1'b0, x[SumW-1:0]} + {{(SumW+1-(TotalW-SumW)){1'b0}}, x[TotalW-1:SumW]};
    t2 = {1'b0, t1[SumW-1:0]} + {{SumW{1'b0}}, t1[SumW]};
    return t2[SumW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/icsum_accum.sv =====
`default_nettype none

module icsum_accum (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               fire_i,
  input  wire icsum_pkg::in_item_t item_i,
  output icsum_pkg::fin_t         fin_o
);

  logic [icsum_pkg::SumW-1:0]   sum_q, sum_d;
  logic [icsum_pkg::CountW-1:0] count_q, count_d;
  logic [7:0]                   held_q, held_d;
  logic                         odd_q, odd_d;

  logic [icsum_pkg::SumW-1:0]   w0, w1, w2, w3;
  logic [icsum_pkg::TotalW-1:0] total;

  // Select the words this item contributes.
  always_comb begin
    w0 = '0;
    w1 = '0;
    w2 = '0;
    w3 = '0;
    held_d = held_q;
    odd_d  = odd_q;
    case (item_i.kind)
      icsum_pkg::KIND_ADDR: begin
        w0 = item_i.address_chunk[63:48];
        w1 = item_i.address_chunk[47:32];
        w2 = item_i.address_chunk[31:16];
        w3 = item_i.address_chunk[15:0];
      end
      icsum_pkg::KIND_HDR: begin
        w0 = {8'h00, item_i.next_header};
        w1 = {item_i.icmp_type, item_i.icmp_code};
        w2 = item_i.ident;
        w3 = item_i.sequence_req;
      end
      icsum_pkg::KIND_PAYLOAD: begin
        if (odd_q) begin
          w0    = {held_q, item_i.payload_byte};
          odd_d = 1'b0;
        end else begin
          held_d = item_i.payload_byte;
          odd_d  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Ones'-complement sum of the running value and up to four new words.
  always_comb begin
    total = {3'b000, sum_q} + {3'b000, w0} + {3'b000, w1}
          + {3'b000, w2} + {3'b000, w3};
    sum_d = icsum_pkg::ones_fold(total);
  end

  // Saturating payload byte count.
  always_comb begin
    count_d = count_q;
    if (item_i.kind == icsum_pkg::KIND_PAYLOAD && count_q != icsum_pkg::CountMax) begin
      count_d = count_q + 17'd1;
    end
  end

  // State as it stands after this item, for the finishing stage.
  always_comb begin
    fin_o.sum      = sum_d;
    fin_o.pad_word = odd_d ? {held_d, 8'h00} : '0;
    fin_o.count    = count_d;
  end

  // Message state; a last item clears it for the next message.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
      held_q  <= '0;
      odd_q   <= 1'b0;
    end else if (fire_i) begin
      if (item_i.last) begin
        sum_q   <= '0;
        count_q <= '0;
        held_q  <= '0;
        odd_q   <= 1'b0;
      end else begin
        sum_q   <= sum_d;
        count_q <= count_d;
        held_q  <= held_d;
        odd_q   <= odd_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/icsum_final.sv =====
`default_nettype none

module icsum_final (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            load_i,
  input  wire icsum_pkg::fin_t fin_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [15:0]          checksum_value_o,
  output logic                 length_error_o
);

  icsum_pkg::fin_t fin_q;
  logic            fin_v_q, fin_v_d;
  logic [15:0]     chk_q, chk_d;
  logic            err_q, err_d;
  logic            out_v_q, out_v_d;

  logic                         move;
  logic [icsum_pkg::SumW-1:0]   len_word;
  logic [icsum_pkg::TotalW-1:0] total;

  // A finished message moves on when the result register is free or emptying.
  assign move       = fin_v_q && (!out_v_q || out_ready_i);
  assign in_ready_o = !fin_v_q || move;

  // Pad word, upper-layer length and complement.
  always_comb begin
    len_word = fin_q.count[icsum_pkg::SumW-1:0] + icsum_pkg::IcmpHeaderBytes;
    total    = {3'b000, fin_q.sum} + {3'b000, fin_q.pad_word} + {3'b000, len_word};
    chk_d    = ~icsum_pkg::ones_fold(total);
    err_d    = fin_q.count > icsum_pkg::PayloadLimit;
  end

  always_comb begin
    fin_v_d = fin_v_q;
    if (load_i) begin
      fin_v_d = 1'b1;
    end else if (move) begin
      fin_v_d = 1'b0;
    end
    out_v_d = out_v_q;
    if (move) begin
      out_v_d = 1'b1;
    end else if (out_ready_i) begin
      out_v_d = 1'b0;
    end
  end

  // Valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      fin_v_q <= fin_v_d;
      out_v_q <= out_v_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      fin_q <= fin_i;
    end
    if (move) begin
      chk_q <= chk_d;
      err_q <= err_d;
    end
  end

  assign out_valid_o      = out_v_q;
  assign checksum_value_o = chk_q;
  assign length_error_o   = err_q;

endmodule

`default_nettype wire

// ===== design/icmpv6_checksum_engine_unit.sv =====
`default_nettype none

// ICMPv6 checksum engine. Feed each message as four address items (kind 0,
// source then destination, 64 bits each, big-endian), one header item
// (kind 1) and one payload byte per item (kind 2), with tlast on the final
// item; one result per message appears on the output stream holding the
// checksum field word and a length error flag for payloads over 65527
// bytes. The engine takes one item every cycle while input ready is high:
// the ones'-complement add of up to four words into the running sum is a
// single registered step, and the pad, length and complement of a finished
// message are done in a separate result stage that feeds the output
// register. Input ready drops only while a finished message waits behind a
// result that the output side has not taken.
module icmpv6_checksum_engine_unit (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // address_chunk[63:0], next_header[71:64], icmp_type[79:72],
  // icmp_code[87:80], ident[103:88], sequence_req[119:104],
  // payload_byte[127:120]
  input  wire logic [127:0] s_axis_tdata_i,
  // kind[1:0]
  input  wire logic [1:0]   s_axis_tuser_i,
  input  wire logic         s_axis_tlast_i,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // checksum_value[15:0]
  output logic [15:0]       m_axis_tdata_o,
  // length_error[0]
  output logic              m_axis_tuser_o
);

  icsum_pkg::in_item_t item;
  icsum_pkg::fin_t     fin;
  logic                fire;

  // Unpack the input item.
  always_comb begin
    item.kind          = icsum_pkg::kind_e'(s_axis_tuser_i);
    item.address_chunk = s_axis_tdata_i[63:0];
    item.next_header   = s_axis_tdata_i[71:64];
    item.icmp_type     = s_axis_tdata_i[79:72];
    item.icmp_code     = s_axis_tdata_i[87:80];
    item.ident         = s_axis_tdata_i[103:88];
    item.sequence_req  = s_axis_tdata_i[119:104];
    item.payload_byte  = s_axis_tdata_i[127:120];
    item.last          = s_axis_tlast_i;
  end

  assign fire = s_axis_tvalid_i && s_axis_tready_o;

  icsum_accum u_accum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item),
    .fin_o  (fin)
  );

  icsum_final u_final (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .load_i           (fire && s_axis_tlast_i),
    .fin_i            (fin),
    .in_ready_o       (s_axis_tready_o),
    .out_valid_o      (m_axis_tvalid_o),
    .out_ready_i      (m_axis_tready_i),
    .checksum_value_o (m_axis_tdata_o),
    .length_error_o   (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

// ===== design/icsum_checker.sv =====
`default_nettype none

module icsum_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid_i,
  input wire logic         s_axis_tready_o,
  input wire logic         s_axis_tlast_i,
  input wire logic         m_axis_tvalid_o,
  input wire logic         m_axis_tready_i,
  input wire logic [15:0]  m_axis_tdata_o,
  input wire logic         m_axis_tuser_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its value.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // A fresh result follows an accepted last item through the result stage.
  a_out_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i, 2))
    else $error("result without a matching last item");

  // Input stalls only behind a stalled output.
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled while output free");

endmodule

bind icmpv6_checksum_engine_unit icsum_checker u_icsum_checker (.*);

`default_nettype wire

// ===== tb/icmpv6_checksum_engine_unit_tb.sv =====
`timescale 1ns / 1ps

module icmpv6_checksum_engine_unit_tb;

  // Kind code that the engine ignores apart from its tlast.
  localparam logic [1:0] KindUnused = 2'd3;

  localparam int DirRows     = 21;
  localparam int FedTarget   = 1500;
  localparam int QuietTail   = 250;
  localparam int HoldCycles  = 300;
  localparam int StallLimit  = 2000;
  localparam int DrainCycles = 8;
  localparam int ShownErrors = 10;

  typedef struct packed {
    logic [1:0]   kind;
    logic [127:0] data;
    logic         last;
  } stim_t;

  typedef struct packed {
    logic [15:0] csum;
    logic        len_err;
  } csum_res_t;

  typedef struct packed {
    stim_t     item;
    logic      typed;
    csum_res_t res;
  } dir_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_valid = 1'b0;
  logic [1:0]   s_kind = '0;
  logic [127:0] s_data = '0;
  logic         s_last = 1'b0;
  logic         m_ready = 1'b0;
  logic         s_axis_tready_o;
  logic         m_axis_tvalid_o;
  logic [15:0]  m_axis_tdata_o;
  logic         m_axis_tuser_o;

  // Shared controls of the traffic shaping.
  bit idle_on = 1'b1;
  bit stall_out_req = 1'b0;

  // Mirror of the engine's message state.
  logic [15:0] acc_sum = '0;
  logic [16:0] byte_cnt = '0;
  logic [7:0]  hold_byte = '0;
  logic        odd_byte = 1'b0;
  logic        len_over = 1'b0;

  csum_res_t csum_q[$];
  dir_row_t  dir_tab[DirRows];
  int        fed_items = 0;
  int        result_cnt = 0;
  int        mismatches = 0;
  int        quiet_cycles = 0;
  csum_res_t want;

  always #6 clk_i = ~clk_i;

  icmpv6_checksum_engine_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_kind),
    .s_axis_tlast_i (s_last),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  // Ones'-complement add of one 16-bit word with end-around carry.
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  function automatic logic [127:0] pack_fields(input logic [63:0] chunk,
                                               input logic [7:0] nh, input logic [7:0] ty,
                                               input logic [7:0] co, input logic [15:0] id,
                                               input logic [15:0] sq, input logic [7:0] pb);
    return {pb, sq, id, co, ty, nh, chunk};
  endfunction

  function automatic logic [127:0] rand_data();
    logic [127:0] d;
    d = {$urandom, $urandom, $urandom, $urandom};
    // Now and then an all-zeros or all-ones item.
    case ($urandom_range(0, 19))
      0: d = '0;
      1: d = '1;
      default: ;
    endcase
    return d;
  endfunction

  function automatic dir_row_t mk_row(input logic [1:0] kind, input logic [127:0] data,
                                      input logic last, input logic typed,
                                      input logic [15:0] csum, input logic len_err);
    dir_row_t r;
    r.item.kind = kind;
    r.item.data = data;
    r.item.last = last;
    r.typed = typed;
    r.res.csum = csum;
    r.res.len_err = len_err;
    return r;
  endfunction

  // Advance the checksum state by one accepted item.
  task automatic track_item(input stim_t it, output bit has_res, output csum_res_t res);
    has_res = 1'b0;
    res = '0;
    case (it.kind)
      icsum_pkg::KIND_ADDR: begin
        for (int i = 3; i >= 0; i--) acc_sum = oc_add(acc_sum, it.data[16*i +: 16]);
      end
      icsum_pkg::KIND_HDR: begin
        acc_sum = oc_add(acc_sum, {8'h00, it.data[71:64]});
        acc_sum = oc_add(acc_sum, {it.data[79:72], it.data[87:80]});
        acc_sum = oc_add(acc_sum, it.data[103:88]);
        acc_sum = oc_add(acc_sum, it.data[119:104]);
      end
      icsum_pkg::KIND_PAYLOAD: begin
        if (odd_byte) begin
          acc_sum = oc_add(acc_sum, {hold_byte, it.data[127:120]});
          odd_byte = 1'b0;
        end else begin
          hold_byte = it.data[127:120];
          odd_byte = 1'b1;
        end
        if (byte_cnt < icsum_pkg::CountMax) byte_cnt = byte_cnt + 17'd1;
        if (byte_cnt > icsum_pkg::PayloadLimit) len_over = 1'b1;
      end
      default: ;
    endcase
    if (it.last) begin
      if (odd_byte) acc_sum = oc_add(acc_sum, {hold_byte, 8'h00});
      acc_sum = oc_add(acc_sum, byte_cnt[15:0] + icsum_pkg::IcmpHeaderBytes);
      res.csum = ~acc_sum;
      res.len_err = len_over;
      has_res = 1'b1;
      acc_sum = '0;
      byte_cnt = '0;
      hold_byte = '0;
      odd_byte = 1'b0;
      len_over = 1'b0;
    end
  endtask

  // Offer one item, wait for it to be taken and record what it should produce.
  task automatic send_item(input stim_t it, input logic typed, input csum_res_t typed_res);
    bit        has_res;
    csum_res_t res;
    if (idle_on && $urandom_range(0, 99) < 20) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_kind  <= it.kind;
    s_data  <= it.data;
    s_last  <= it.last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    if (it.kind != KindUnused) fed_items++;
    track_item(it, has_res, res);
    if (has_res) csum_q.push_back(typed ? typed_res : res);
  endtask

  // A well-formed message: four address items, the header, then the payload.
  task automatic send_msg(input int n_bytes);
    stim_t it;
    for (int i = 0; i < n_bytes + 5; i++) begin
      it.kind = (i < 4) ? icsum_pkg::KIND_ADDR :
                (i == 4) ? icsum_pkg::KIND_HDR : icsum_pkg::KIND_PAYLOAD;
      it.data = rand_data();
      it.last = (i == n_bytes + 4);
      send_item(it, 1'b0, '0);
    end
  endtask

  // Output side: ready pattern, with one long hold-off on request.
  initial begin
    wait (rst_ni === 1'b1);
    forever begin
      if (stall_out_req) begin
        stall_out_req = 1'b0;
        m_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 99) < 30) begin
        m_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end else begin
        m_ready <= 1'b1;
        repeat (idle_on ? $urandom_range(1, 12) : 1) @(posedge clk_i);
      end
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_ready) begin
      result_cnt++;
      if (csum_q.size() == 0) begin
        mismatches++;
        if (mismatches <= ShownErrors)
          $display("result %0d arrived with no expectation pending: %h/%0d",
                   result_cnt, m_axis_tdata_o, m_axis_tuser_o);
      end else begin
        want = csum_q.pop_front();
        if (m_axis_tdata_o !== want.csum || m_axis_tuser_o !== want.len_err) begin
          mismatches++;
          if (mismatches <= ShownErrors)
            $display("result %0d: checksum exp %h got %h, length_error exp %0d got %0d",
                     result_cnt, want.csum, m_axis_tdata_o, want.len_err, m_axis_tuser_o);
        end
      end
    end
  end

  // Watchdog on cycles in which neither side moves an item.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= StallLimit) begin
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

  // Stimulus.
  initial begin
    // Directed messages; expected values typed in for the trivial ones.
    dir_tab[0]  = mk_row(KindUnused, '1, 1'b1, 1'b1, 16'hfff7, 1'b0);
    dir_tab[1]  = mk_row(icsum_pkg::KIND_ADDR, '1, 1'b1, 1'b1, 16'hfff7, 1'b0);
    dir_tab[2]  = mk_row(icsum_pkg::KIND_ADDR, '0, 1'b1, 1'b1, 16'hfff7, 1'b0);
    dir_tab[3]  = mk_row(icsum_pkg::KIND_HDR, '0, 1'b1, 1'b1, 16'hfff7, 1'b0);
    dir_tab[4]  = mk_row(icsum_pkg::KIND_HDR, '1, 1'b1, 1'b1, 16'hfef8, 1'b0);
    dir_tab[5]  = mk_row(icsum_pkg::KIND_PAYLOAD, '1, 1'b1, 1'b1, 16'h00f6, 1'b0);
    dir_tab[6]  = mk_row(icsum_pkg::KIND_PAYLOAD, '0, 1'b1, 1'b1, 16'hfff6, 1'b0);
    // A typical echo request with a three-byte payload.
    dir_tab[7]  = mk_row(icsum_pkg::KIND_ADDR, 128'h2001_0db8_0000_0000, 1'b0, 1'b0, '0, 1'b0);
    dir_tab[8]  = mk_row(icsum_pkg::KIND_ADDR, 128'h0000_0000_0000_0001, 1'b0, 1'b0, '0, 1'b0);
    dir_tab[9]  = mk_row(icsum_pkg::KIND_ADDR, 128'hfe80_0000_0000_0000, 1'b0, 1'b0, '0, 1'b0);
    dir_tab[10] = mk_row(icsum_pkg::KIND_ADDR, 128'h0211_22ff_fe33_4455, 1'b0, 1'b0, '0, 1'b0);
    dir_tab[11] = mk_row(icsum_pkg::KIND_HDR, pack_fields('1, 8'd58, 8'd128, 8'd0, 16'h1234,
                                               16'h0001, 8'hff), 1'b0, 1'b0, '0, 1'b0);
    dir_tab[12] = mk_row(icsum_pkg::KIND_PAYLOAD, pack_fields('0, 8'hff, 8'h00, 8'hff, 16'h0000,
                                                   16'hffff, 8'h61), 1'b0, 1'b0, '0, 1'b0);
    dir_tab[13] = mk_row(icsum_pkg::KIND_PAYLOAD, pack_fields('1, 8'h00, 8'hff, 8'h00, 16'hffff,
                                                   16'h0000, 8'h62), 1'b0, 1'b0, '0, 1'b0);
    dir_tab[14] = mk_row(icsum_pkg::KIND_PAYLOAD, pack_fields('0, 8'h00, 8'h00, 8'h00, 16'h0000,
                                                   16'h0000, 8'h63), 1'b1, 1'b0, '0, 1'b0);
    // Unused kind in the middle and as the finishing item.
    dir_tab[15] = mk_row(icsum_pkg::KIND_PAYLOAD, pack_fields('1, 8'hff, 8'hff, 8'hff, 16'hffff,
                                                   16'hffff, 8'ha5), 1'b0, 1'b0, '0, 1'b0);
    dir_tab[16] = mk_row(KindUnused, '1, 1'b0, 1'b0, '0, 1'b0);
    dir_tab[17] = mk_row(KindUnused, pack_fields('1, 8'h5a, 8'h00, 8'h00, 16'h0,
                                                 16'h0, 8'h5a), 1'b1, 1'b0, '0, 1'b0);
    // Odd item counts: one address item and a repeated header.
    dir_tab[18] = mk_row(icsum_pkg::KIND_ADDR, 128'h8000_0000_0000_0001, 1'b0, 1'b0, '0, 1'b0);
    dir_tab[19] = mk_row(icsum_pkg::KIND_HDR, pack_fields('0, 8'h80, 8'h01, 8'h80, 16'h8001,
                                               16'h7ffe, 8'h00), 1'b0, 1'b0, '0, 1'b0);
    dir_tab[20] = mk_row(icsum_pkg::KIND_HDR, pack_fields('0, 8'h7f, 8'hfe, 8'h7f, 16'h7ffe,
                                               16'h8001, 8'h00), 1'b1, 1'b0, '0, 1'b0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DirRows; r++) send_item(dir_tab[r].item, dir_tab[r].typed, dir_tab[r].res);

    // Random traffic: mostly well-formed messages, some broken sequences.
    fed_items = 0;
    for (int m = 0; fed_items < FedTarget; m++) begin
      stim_t it;
      int    n;
      if (m == 3) stall_out_req = 1'b1;
      if (fed_items > FedTarget - QuietTail) idle_on = 1'b0;
      if ($urandom_range(0, 99) < 80) begin
        case ($urandom_range(0, 19))
          0: n = $urandom_range(100, 400);
          1, 2, 3, 4, 5: n = $urandom_range(21, 100);
          default: n = $urandom_range(0, 20);
        endcase
        send_msg(n);
      end else begin
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) begin
          it.kind = 2'($urandom_range(0, 3));
          it.data = rand_data();
          it.last = (i == n - 1);
          send_item(it, 1'b0, '0);
        end
      end
    end
    s_valid <= 1'b0;

    // Drain the outstanding results.
    while (csum_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
